FILE: rtl/rrap_pkg.sv
package rrap_pkg;

    // field and register widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned PART_W   = 16;
    localparam int unsigned VALUE_W  = 30;
    localparam int unsigned CFG_W    = 30;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned DIGIT_W  = 4;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PART_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BULK_LENGTH = 1'b1;

    // configuration reset values
    localparam logic [PART_W-1:0]  MAX_PART_COUNT_RST  = 16'd1024;
    localparam logic [VALUE_W-1:0] MAX_BULK_LENGTH_RST = 30'd536870912;

    // protocol characters
    localparam logic [BYTE_W-1:0] CHR_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CHR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE   = 8'h39;

    // byte kinds reported per item
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 3'd0,
        KIND_CMD    = 3'd1,
        KIND_ARG    = 3'd2,
        KIND_TERM   = 3'd3,
        KIND_ERROR  = 3'd4
    } t_kind;

    // byte classes decided by the front
    typedef enum logic [2:0] {
        CLS_OTHER  = 3'd0,
        CLS_STAR   = 3'd1,
        CLS_DOLLAR = 3'd2,
        CLS_CR     = 3'd3,
        CLS_LF     = 3'd4,
        CLS_DIGIT  = 3'd5
    } t_byte_class;

    // parser phases
    typedef enum logic [3:0] {
        PH_WAIT_STAR  = 4'd0,
        PH_COUNT_DIG  = 4'd1,
        PH_COUNT_LF   = 4'd2,
        PH_LEN_PREFIX = 4'd3,
        PH_LEN_DIG    = 4'd4,
        PH_LEN_LF     = 4'd5,
        PH_PAYLOAD    = 4'd6,
        PH_TERM1      = 4'd7,
        PH_TERM2      = 4'd8
    } t_phase;

    // one classified byte as it travels through the queue
    typedef struct packed {
        t_byte_class         cls;
        logic [DIGIT_W-1:0]  digit;
    } t_item;

endpackage

FILE: rtl/rrap_front.sv
module rrap_front
    import rrap_pkg::*;
(
    input  logic              i_in_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_full,
    output logic              o_in_ready,
    output logic              o_push,
    output t_item             o_item
);

    // take a byte whenever the queue has room
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // classify the byte for the back end
    always_comb begin
        o_item.digit = i_in_byte[DIGIT_W-1:0];
        if (i_in_byte >= CHR_ZERO && i_in_byte <= CHR_NINE) begin
            o_item.cls = CLS_DIGIT;
        end else if (i_in_byte == CHR_STAR) begin
            o_item.cls = CLS_STAR;
        end else if (i_in_byte == CHR_DOLLAR) begin
            o_item.cls = CLS_DOLLAR;
        end else if (i_in_byte == CHR_CR) begin
            o_item.cls = CLS_CR;
        end else if (i_in_byte == CHR_LF) begin
            o_item.cls = CLS_LF;
        end else begin
            o_item.cls = CLS_OTHER;
        end
    end

endmodule

FILE: rtl/rrap_queue.sv
module rrap_queue
    import rrap_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // pointer wrap
    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/rrap_back.sv
module rrap_back
    import rrap_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KIND_W-1:0]    o_byte_kind,
    output logic [PART_W-1:0]    o_part_number,
    output logic [VALUE_W-1:0]   o_header_value,
    output logic                 o_header_complete,
    output logic                 o_header_is_count,
    output logic                 o_message_end
);

    localparam int unsigned MUL_W = VALUE_W + 4;

    // configuration
    logic [PART_W-1:0]  r_max_part_count;
    logic [VALUE_W-1:0] r_max_bulk_length;

    // parser state
    t_phase             r_phase;
    t_phase             n_phase;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic               r_digit_seen;
    logic               n_digit_seen;
    logic [PART_W-1:0]  r_parts_left;
    logic [PART_W-1:0]  n_parts_left;
    logic [VALUE_W-1:0] r_bytes_left;
    logic [VALUE_W-1:0] n_bytes_left;
    logic [PART_W-1:0]  r_cur_part;
    logic [PART_W-1:0]  n_cur_part;

    // output register
    logic               r_out_valid;
    t_kind              r_kind;
    t_kind              n_kind;
    logic [PART_W-1:0]  r_part;
    logic [PART_W-1:0]  n_part;
    logic [VALUE_W-1:0] r_hval;
    logic [VALUE_W-1:0] n_hval;
    logic               r_hdone;
    logic               n_hdone;
    logic               r_hcount;
    logic               n_hcount;
    logic               r_mend;
    logic               n_mend;

    // shared decode
    logic               step;
    logic               is_digit;
    logic               cr_ok;
    logic [MUL_W-1:0]   mul_val;
    logic [MUL_W-1:0]   limit_val;
    logic               over;
    logic               idle;

    assign step     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop  = step;
    assign is_digit = (i_q_item.cls == CLS_DIGIT);
    assign cr_ok    = (i_q_item.cls == CLS_CR) && r_digit_seen;

    // accumulate times ten plus digit, against the active limit
    assign mul_val   = (MUL_W'(r_acc) << 3) + (MUL_W'(r_acc) << 1)
                     + MUL_W'(i_q_item.digit);
    assign limit_val = (r_phase == PH_COUNT_DIG) ? MUL_W'(r_max_part_count)
                                                 : MUL_W'(r_max_bulk_length);
    assign over      = (mul_val > limit_val);

    // next phase
    always_comb begin
        unique case (r_phase)
            PH_WAIT_STAR: begin
                n_phase = (i_q_item.cls == CLS_STAR) ? PH_COUNT_DIG : PH_WAIT_STAR;
            end
            PH_COUNT_DIG: begin
                if (is_digit && !over) begin
                    n_phase = PH_COUNT_DIG;
                end else if (!is_digit && cr_ok) begin
                    n_phase = PH_COUNT_LF;
                end else begin
                    n_phase = PH_WAIT_STAR;
                end
            end
            PH_COUNT_LF: begin
                if (i_q_item.cls == CLS_LF && r_acc != '0) begin
                    n_phase = PH_LEN_PREFIX;
                end else begin
                    n_phase = PH_WAIT_STAR;
                end
            end
            PH_LEN_PREFIX: begin
                n_phase = (i_q_item.cls == CLS_DOLLAR) ? PH_LEN_DIG : PH_WAIT_STAR;
            end
            PH_LEN_DIG: begin
                if (is_digit && !over) begin
                    n_phase = PH_LEN_DIG;
                end else if (!is_digit && cr_ok) begin
                    n_phase = PH_LEN_LF;
                end else begin
                    n_phase = PH_WAIT_STAR;
                end
            end
            PH_LEN_LF: begin
                if (i_q_item.cls != CLS_LF) begin
                    n_phase = PH_WAIT_STAR;
                end else if (r_acc == '0) begin
                    n_phase = PH_TERM1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_phase = (r_bytes_left == VALUE_W'(1)) ? PH_TERM1 : PH_PAYLOAD;
            end
            PH_TERM1: begin
                n_phase = PH_TERM2;
            end
            PH_TERM2: begin
                n_phase = (r_parts_left == PART_W'(1)) ? PH_WAIT_STAR : PH_LEN_PREFIX;
            end
            default: begin
                n_phase = PH_WAIT_STAR;
            end
        endcase
    end

    // result fields and counter updates
    always_comb begin
        n_kind       = KIND_HEADER;
        n_part       = r_cur_part;
        n_hval       = '0;
        n_hdone      = 1'b0;
        n_hcount     = 1'b0;
        n_mend       = 1'b0;
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_parts_left = r_parts_left;
        n_bytes_left = r_bytes_left;
        n_cur_part   = r_cur_part;
        idle         = 1'b0;
        unique case (r_phase) inside
            PH_COUNT_DIG, PH_LEN_DIG: begin
                if (is_digit && !over) begin
                    n_acc        = mul_val[VALUE_W-1:0];
                    n_digit_seen = 1'b1;
                end else if (is_digit || !cr_ok) begin
                    idle   = 1'b1;
                    n_kind = KIND_ERROR;
                end
            end
            PH_COUNT_LF: begin
                if (i_q_item.cls != CLS_LF) begin
                    idle   = 1'b1;
                    n_kind = KIND_ERROR;
                end else begin
                    n_hval   = r_acc;
                    n_hdone  = 1'b1;
                    n_hcount = 1'b1;
                    if (r_acc == '0) begin
                        n_mend = 1'b1;
                        idle   = 1'b1;
                    end else begin
                        n_parts_left = r_acc[PART_W-1:0];
                        n_cur_part   = '0;
                    end
                end
            end
            PH_LEN_PREFIX: begin
                if (i_q_item.cls == CLS_DOLLAR) begin
                    n_acc        = '0;
                    n_digit_seen = 1'b0;
                end else begin
                    idle   = 1'b1;
                    n_kind = KIND_ERROR;
                end
            end
            PH_LEN_LF: begin
                if (i_q_item.cls != CLS_LF) begin
                    idle   = 1'b1;
                    n_kind = KIND_ERROR;
                end else begin
                    n_hval       = r_acc;
                    n_hdone      = 1'b1;
                    n_bytes_left = r_acc;
                end
            end
            PH_PAYLOAD: begin
                n_kind       = (r_cur_part == '0) ? KIND_CMD : KIND_ARG;
                n_bytes_left = r_bytes_left - 1'b1;
            end
            PH_TERM1: begin
                n_kind = KIND_TERM;
            end
            PH_TERM2: begin
                n_kind       = KIND_TERM;
                n_parts_left = r_parts_left - 1'b1;
                if (r_parts_left == PART_W'(1)) begin
                    n_mend = 1'b1;
                    idle   = 1'b1;
                end else begin
                    n_cur_part = r_cur_part + 1'b1;
                end
            end
            default: begin
                // waiting for the array prefix
                idle   = 1'b1;
                n_part = '0;
                if (i_q_item.cls != CLS_STAR) begin
                    n_kind = KIND_ERROR;
                end
            end
        endcase
        // drop all counters on error, end of message or new request
        if (idle) begin
            n_acc        = '0;
            n_digit_seen = 1'b0;
            n_parts_left = '0;
            n_bytes_left = '0;
            n_cur_part   = '0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_part_count  <= MAX_PART_COUNT_RST;
            r_max_bulk_length <= MAX_BULK_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_PART_COUNT:  r_max_part_count  <= i_cfg_data[PART_W-1:0];
                CFG_MAX_BULK_LENGTH: r_max_bulk_length <= i_cfg_data[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT_STAR;
            r_acc        <= '0;
            r_digit_seen <= 1'b0;
            r_parts_left <= '0;
            r_bytes_left <= '0;
            r_cur_part   <= '0;
        end else if (step) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_digit_seen <= n_digit_seen;
            r_parts_left <= n_parts_left;
            r_bytes_left <= n_bytes_left;
            r_cur_part   <= n_cur_part;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_kind   <= n_kind;
            r_part   <= n_part;
            r_hval   <= n_hval;
            r_hdone  <= n_hdone;
            r_hcount <= n_hcount;
            r_mend   <= n_mend;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_kind       = r_kind;
    assign o_part_number     = r_part;
    assign o_header_value    = r_hval;
    assign o_header_complete = r_hdone;
    assign o_header_is_count = r_hcount;
    assign o_message_end     = r_mend;

endmodule

FILE: rtl/resp_request_array_parser.sv
// an accepted byte is written into the queue, then parsed into the output register
// throughput: one byte per cycle in the back end parser step, unless the output is held
// a queue of QUEUE_DEPTH entries sits between the byte classifier and the parser
// reset: synchronous active low; clears parser state, queue and output valid,
// and loads the default limits; no clearing pass, input is taken right after reset
module resp_request_array_parser
    import rrap_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_in_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KIND_W-1:0]    o_byte_kind,
    output logic [PART_W-1:0]    o_part_number,
    output logic [VALUE_W-1:0]   o_header_value,
    output logic                 o_header_complete,
    output logic                 o_header_is_count,
    output logic                 o_message_end
);

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    t_item front_item;
    t_item head_item;

    // byte classifier
    rrap_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_full     (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (q_push),
        .o_item     (front_item)
    );

    // queue between classifier and parser
    rrap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    // framing state machine and output register
    rrap_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_q_valid         (q_valid),
        .i_q_item          (head_item),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_byte_kind       (o_byte_kind),
        .o_part_number     (o_part_number),
        .o_header_value    (o_header_value),
        .o_header_complete (o_header_complete),
        .o_header_is_count (o_header_is_count),
        .o_message_end     (o_message_end)
    );

`ifndef SYNTHESIS
    // a count header is always a completed header
    a_count_needs_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_header_is_count |-> o_header_complete)
        else $error("count flag without completed header");

    // header value only shown on a completed header
    a_value_only_on_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_header_complete |-> o_header_value == '0)
        else $error("header value outside completed header");

    // a message ends on a terminator or on a zero count header
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_end |->
            (o_byte_kind == KIND_TERM) || (o_header_is_count && o_header_value == '0))
        else $error("message end on unexpected byte");

    // completed header is never reported as an error or payload
    a_complete_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_header_complete |-> o_byte_kind == KIND_HEADER)
        else $error("completed header with wrong kind");
`endif

endmodule
